FILE: rtl/svf_pkg.sv
// svf_pkg: shared types, constants and helper functions of the stereo svf lowpass
// standalone: no dependencies
package svf_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int TAN_DEPTH_DEF  = 1024;
   localparam int FS_W           = 18;
   localparam int FC_W           = 15;
   localparam int RES_W          = 13;
   localparam int TAB_W          = 40;
   localparam int G_W            = 32;
   localparam int COEF_W         = 29;
   localparam int DEN_W          = 38;
   localparam int QUO_W          = 29;
   localparam int STEP_W         = 5;
   localparam int K_W            = 14;
   localparam int G_SHIFT        = 24;
   localparam int COEF_SHIFT     = 28;
   localparam int A1_STEPS       = 29;
   localparam int LIM_NUM        = 49;
   localparam int LIM_DEN        = 100;
   localparam int LIM_Y_W        = 24;
   localparam int TAYLOR_TERMS   = 12;

   localparam logic [FS_W-1:0]    FS_RESET   = 18'd48000;
   localparam logic [RES_W-1:0]   RES_ONE    = 13'd4096;
   localparam logic [25:0]        LIM_RECIP  = 26'd42949672;
   localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;
   localparam logic [63:0]        ONE_Q30     = 64'd1073741824;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic [FC_W-1:0]               cutoff_hz;
      logic [RES_W-1:0]              resonance;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_word_type;

   typedef struct packed {
      logic [COEF_W-1:0] a1;
      logic [COEF_W-1:0] a2;
      logic [COEF_W-1:0] a3;
   } coef_type;

   typedef struct packed {
      logic              start;
      logic [DEN_W-1:0]  rem_init;
      logic [QUO_W-1:0]  low_bits;
      logic [DEN_W-1:0]  denom;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

   typedef enum logic [3:0] {
      CF_IDLE, CF_LIM, CF_CLAMP, CF_POS, CF_POS_WAIT, CF_RD0, CF_RD1, CF_RD2,
      CF_INTERP, CF_DEN, CF_A1, CF_A1_WAIT, CF_A2, CF_A3, CF_DONE
   } coef_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE, TOP_COEF, TOP_LANE, TOP_MERGE
   } top_state_type;

   // bit-serial long division, elaboration time only
   function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // tan(i*(pi/2)/depth) in Q.24 from truncated taylor series of sin and cos
   function automatic logic [TAB_W-1:0] tan_entry(int unsigned i, int unsigned depth);
      logic [63:0] th;
      logic [63:0] th2;
      logic [63:0] st;
      logic [63:0] ct;
      logic signed [63:0] s;
      logic signed [63:0] c;
      logic [63:0] q;
      th  = udiv64(64'(i) * PI_HALF_Q30, 64'(depth));
      th2 = (th * th) >> 30;
      st  = th;
      ct  = ONE_Q30;
      s   = $signed(th);
      c   = $signed(ONE_Q30);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         st = udiv64((st * th2) >> 30, 64'((2 * n) * (2 * n + 1)));
         ct = udiv64((ct * th2) >> 30, 64'((2 * n - 1) * (2 * n)));
         if ((n % 2) == 1) begin
            s = s - $signed(st);
            c = c - $signed(ct);
         end else begin
            s = s + $signed(st);
            c = c + $signed(ct);
         end
      end
      if (s < 0) s = '0;
      if (c < 1) c = 64'sd1;
      q = udiv64($unsigned(s) << G_SHIFT, $unsigned(c));
      return q[TAB_W-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [39:0] v);
      if (v > 40'sd2147483647) return 32'sh7fffffff;
      if (v < -40'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [39:0] v);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = (40'sd1 <<< (SAMPLE_BITS - 1)) - 40'sd1;
      lo = -hi - 40'sd1;
      if (v > hi) return hi[SAMPLE_BITS-1:0];
      if (v < lo) return lo[SAMPLE_BITS-1:0];
      return v[SAMPLE_BITS-1:0];
   endfunction

   // divide by 2^28, rounding half away from zero
   function automatic logic signed [36:0] round_q28(logic signed [63:0] v);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] sum;
      logic signed [36:0] r;
      neg = v[63];
      mag = neg ? $unsigned(-v) : $unsigned(v);
      sum = mag + (64'd1 << (COEF_SHIFT - 1));
      r   = $signed({1'b0, sum[63:COEF_SHIFT]});
      return neg ? -r : r;
   endfunction

endpackage

FILE: rtl/stereo_svf_lowpass.sv
// stereo_svf_lowpass: top level, coefficient sequencer, two lanes and merge register
// depends on svf_pkg, svf_coef, svf_lane
//
//   channel | direction | handshake         | word
//   req_    | in        | req_valid/stall   | req_word_type (left, right, cutoff, resonance)
//   rsp_    | out       | rsp_valid/stall   | rsp_word_type (left, right lowpass)
//   csr_    | in        | csr_valid/ready   | sample rate in hz, 18 bits
//
// one word at a time: coefficients come first, mostly from the shared serial divider
// (table position, then a1 in 29 bits); then the lanes, the merge and the idle state
// follow; a new req word is taken only once the previous one is in the output register
// reset is synchronous; it clears integrators, control and the rate register (48000)
// req_stall stays high from acceptance until the result moves into the output register
// a stalled rsp word holds; the next req word is taken while it waits
module stereo_svf_lowpass
   import svf_pkg::*;
#(
   parameter int TAN_TABLE_DEPTH = TAN_DEPTH_DEF
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_word_type    req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_word_type    rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [FS_W-1:0] csr_data
);

   top_state_type   state_ff, state_in;
   logic [FS_W-1:0] fs_ff;
   req_word_type    req_ff;
   rsp_word_type    rsp_ff;
   logic            rsp_valid_ff;
   logic            accept;
   logic            coef_done;
   coef_type        coef;
   logic            lane_start;
   logic            left_done, right_done;
   logic signed [SAMPLE_BITS-1:0] left_y, right_y;
   logic            merge_load;
   logic            out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sample rate register, to be written only while no word is in flight
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= FS_RESET;
      end else if (csr_valid && csr_ready) begin
         fs_ff <= csr_data;
      end
   end

   svf_coef #(
      .TAN_TABLE_DEPTH (TAN_TABLE_DEPTH)
   ) u_coef (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .fs    (fs_ff),
      .fc    (req_data.cutoff_hz),
      .res   (req_data.resonance),
      .done  (coef_done),
      .coef  (coef)
   );

   // both channels share coefficients and run in lock step
   svf_lane u_left (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .x     (req_ff.left_in),
      .coef  (coef),
      .done  (left_done),
      .y     (left_y)
   );

   svf_lane u_right (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .x     (req_ff.right_in),
      .coef  (coef),
      .done  (right_done),
      .y     (right_y)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TOP_IDLE:  if (accept) state_in = TOP_COEF;
         TOP_COEF:  if (coef_done) state_in = TOP_LANE;
         TOP_LANE:  if (left_done && right_done) state_in = TOP_MERGE;
         TOP_MERGE: if (out_free) state_in = TOP_IDLE;
         default:   state_in = TOP_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      lane_start = 1'b0;
      merge_load = 1'b0;
      unique case (state_ff)
         TOP_IDLE:  req_stall = 1'b0;
         TOP_COEF:  lane_start = coef_done;
         TOP_MERGE: merge_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      // merge stage: both lane results into one output word
      if (merge_load) begin
         rsp_ff.left_out  <= left_y;
         rsp_ff.right_out <= right_y;
      end
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (merge_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/svf_div.sv
// svf_div: restoring divider, one quotient bit per cycle
// depends on svf_pkg
module svf_div
   import svf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_cmd_type       cmd,
   output logic              done,
   output logic [QUO_W-1:0]  quot
);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    shifted;
   logic              ge;

   assign shifted = {rem_ff, num_ff[QUO_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = cmd.rem_init;
         num_in  = cmd.low_bits;
         cnt_in  = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         num_in = {num_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      cnt_ff <= cnt_in;
      if (cmd.start) den_ff <= cmd.denom;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

FILE: rtl/svf_coef.sv
// svf_coef: per-item coefficient sequencer (cutoff clamp, tangent rom, a1/a2/a3)
// depends on svf_pkg and svf_div
module svf_coef
   import svf_pkg::*;
#(
   parameter int TAN_TABLE_DEPTH = TAN_DEPTH_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [FS_W-1:0]  fs,
   input  logic [FC_W-1:0]  fc,
   input  logic [RES_W-1:0] res,
   output logic             done,
   output coef_type         coef
);

   localparam int DW    = $clog2(TAN_TABLE_DEPTH);
   localparam int POS_W = DW + 16;
   localparam int NUM_W = FC_W + DW + 2;

   typedef logic [TAB_W-1:0] rom_type [TAN_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < TAN_TABLE_DEPTH; i++) r[i] = tan_entry(i, TAN_TABLE_DEPTH);
      return r;
   endfunction

   function automatic logic [15:0] frac16(logic [POS_W-1:0] p);
      return p[15:0];
   endfunction

   localparam rom_type TAN_ROM = build_rom();

   coef_state_type    state_ff, state_in;
   logic [FS_W-1:0]   fs_ff;
   logic [FC_W-1:0]   fc_ff;
   logic [K_W-1:0]    k_ff;
   logic [LIM_Y_W-1:0] lim_y;
   logic [LIM_Y_W-1:0] est_ff;
   logic [LIM_Y_W-1:0] lim_r;
   logic [LIM_Y_W-1:0] lim;
   logic [49:0]       est_prod;
   logic [POS_W-1:0]  pos_ff;
   logic [DW-1:0]     idx;
   logic [DW-1:0]     idx1;
   logic [DW-1:0]     rom_addr;
   logic [TAB_W-1:0]  rom_q_ff;
   logic [TAB_W-1:0]  t0_ff;
   logic [TAB_W-1:0]  t1_ff;
   logic [TAB_W+15:0] dprod;
   logic [G_W-1:0]    g_ff;
   logic [G_W:0]      gk;
   logic [2*G_W:0]    gprod;
   logic [DEN_W-1:0]  den_ff;
   logic [COEF_W-1:0] a1_ff, a2_ff, a3_ff;
   logic [G_W+COEF_W-1:0] ga1, ga2;
   logic [NUM_W-1:0]  fc2d;
   logic              addr_hi;
   div_cmd_type       cmd;
   logic              div_done;
   logic [QUO_W-1:0]  quot;

   svf_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .done  (div_done),
      .quot  (quot)
   );

   // cutoff limit floor(49*fs/100) by reciprocal with one correction
   assign lim_y    = LIM_Y_W'(fs_ff) * LIM_Y_W'(LIM_NUM);
   assign est_prod = 50'(lim_y) * 50'(LIM_RECIP);
   assign lim_r    = lim_y - est_ff * LIM_Y_W'(LIM_DEN);
   assign lim      = (lim_r >= LIM_Y_W'(LIM_DEN)) ? est_ff + LIM_Y_W'(1) : est_ff;

   assign fc2d = NUM_W'(fc_ff) * NUM_W'(2 * TAN_TABLE_DEPTH);

   assign idx  = pos_ff[POS_W-1:16];
   assign idx1 = (idx == DW'(TAN_TABLE_DEPTH - 1)) ? idx : idx + DW'(1);

   assign dprod = (t1_ff - t0_ff) * frac16(pos_ff);
   assign gk    = (G_W+1)'(g_ff) + ((G_W+1)'(k_ff) << 12);
   assign gprod = (2*G_W+1)'(g_ff) * (2*G_W+1)'(gk);
   assign ga1   = (G_W+COEF_W)'(g_ff) * (G_W+COEF_W)'(a1_ff);
   assign ga2   = (G_W+COEF_W)'(g_ff) * (G_W+COEF_W)'(a2_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CF_IDLE:     if (start) state_in = CF_LIM;
         CF_LIM:      state_in = CF_CLAMP;
         CF_CLAMP:    state_in = CF_POS;
         CF_POS:      state_in = CF_POS_WAIT;
         CF_POS_WAIT: if (div_done) state_in = CF_RD0;
         CF_RD0:      state_in = CF_RD1;
         CF_RD1:      state_in = CF_RD2;
         CF_RD2:      state_in = CF_INTERP;
         CF_INTERP:   state_in = CF_DEN;
         CF_DEN:      state_in = CF_A1;
         CF_A1:       state_in = CF_A1_WAIT;
         CF_A1_WAIT:  if (div_done) state_in = CF_A2;
         CF_A2:       state_in = CF_A3;
         CF_A3:       state_in = CF_DONE;
         CF_DONE:     state_in = CF_IDLE;
         default:     state_in = CF_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.start    = 1'b0;
      cmd.rem_init = '0;
      cmd.low_bits = '0;
      cmd.denom    = '0;
      cmd.steps    = '0;
      addr_hi      = 1'b0;
      done         = 1'b0;
      unique case (state_ff)
         CF_POS: begin
            cmd.start    = 1'b1;
            cmd.rem_init = DEN_W'(fc2d >> DW);
            cmd.low_bits = QUO_W'({fc2d[DW-1:0], 16'd0}) << (QUO_W - POS_W);
            cmd.denom    = DEN_W'(fs_ff);
            cmd.steps    = STEP_W'(POS_W);
         end
         CF_A1: begin
            cmd.start    = 1'b1;
            cmd.rem_init = DEN_W'(1) << (G_SHIFT + COEF_SHIFT - A1_STEPS);
            cmd.denom    = den_ff;
            cmd.steps    = STEP_W'(A1_STEPS);
         end
         CF_RD1:  addr_hi = 1'b1;
         CF_DONE: done = 1'b1;
         default: ;
      endcase
   end

   assign rom_addr = addr_hi ? idx1 : idx;

   always_ff @(posedge clock) begin
      rom_q_ff <= TAN_ROM[rom_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CF_IDLE;
      end else begin
         state_ff <= state_in;
      end
      unique case (state_ff)
         CF_IDLE: begin
            fs_ff <= (fs == '0) ? FS_W'(1) : fs;
            fc_ff <= fc;
            k_ff  <= (res > RES_ONE) ? '0 : K_W'({RES_ONE - res, 1'b0});
         end
         CF_LIM:      est_ff <= est_prod[32 +: LIM_Y_W];
         CF_CLAMP:    if (LIM_Y_W'(fc_ff) > lim) fc_ff <= FC_W'(lim);
         CF_POS_WAIT: if (div_done) pos_ff <= quot[POS_W-1:0];
         CF_RD1:      t0_ff <= rom_q_ff;
         CF_RD2:      t1_ff <= rom_q_ff;
         CF_INTERP:   g_ff <= G_W'(t0_ff + dprod[TAB_W+15:16]);
         CF_DEN:      den_ff <= DEN_W'((2*G_W+1)'(1) << G_SHIFT) + DEN_W'(gprod >> G_SHIFT);
         CF_A1_WAIT:  if (div_done) a1_ff <= quot[COEF_W-1:0];
         CF_A2:       a2_ff <= COEF_W'(ga1 >> G_SHIFT);
         CF_A3:       a3_ff <= COEF_W'(ga2 >> G_SHIFT);
         default: ;
      endcase
   end

   assign coef.a1 = a1_ff;
   assign coef.a2 = a2_ff;
   assign coef.a3 = a3_ff;

endmodule

FILE: rtl/svf_lane.sv
// svf_lane: one channel of the trapezoidal integrator update
// depends on svf_pkg
module svf_lane
   import svf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS-1:0] x,
   input  coef_type                      coef,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] y
);

   logic signed [31:0] ic1_ff, ic2_ff;
   logic signed [32:0] v3_ff;
   logic signed [63:0] prod_ff, acc_ff;
   logic signed [36:0] v1_ff;
   logic signed [37:0] v2_ff;
   logic [2:0]         step_ff;
   logic               busy_ff, done_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff;
   logic [COEF_W-1:0]  ma;
   logic signed [32:0] mb;
   logic signed [62:0] mul;
   logic signed [36:0] rnd;
   logic signed [39:0] t1, t2;

   always_comb begin
      unique case (step_ff)
         3'd0:    begin ma = coef.a1; mb = 33'(ic1_ff); end
         3'd1:    begin ma = coef.a2; mb = v3_ff; end
         3'd2:    begin ma = coef.a2; mb = 33'(ic1_ff); end
         default: begin ma = coef.a3; mb = v3_ff; end
      endcase
   end

   assign mul = $signed({1'b0, ma}) * mb;
   assign rnd = round_q28(acc_ff + prod_ff);
   assign t1  = (40'(v1_ff) <<< 1) - 40'(ic1_ff);
   assign t2  = (40'(v2_ff) <<< 1) - 40'(ic2_ff);

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul);
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         ic1_ff  <= '0;
         ic2_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
         v3_ff   <= 33'(x) - 33'(ic2_ff);
      end else if (busy_ff) begin
         step_ff <= step_ff + 3'd1;
         done_ff <= (step_ff == 3'd5);
         unique case (step_ff)
            3'd1, 3'd3: acc_ff <= prod_ff;
            3'd2:       v1_ff  <= rnd;
            3'd4:       v2_ff  <= 38'(ic2_ff) + 38'(rnd);
            3'd5: begin
               ic1_ff  <= sat32(t1);
               ic2_ff  <= sat32(t2);
               y_ff    <= sat_sample(40'(v2_ff));
               busy_ff <= 1'b0;
            end
            default: ;
         endcase
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule
